[src/spq_pkg.sv]
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Entry layout, action and status codes, and the control bundle broadcast to the cells.
// ----------------------------------------------------------------------------
package spq_pkg;

   // Queue geometry
   localparam int DEPTH       = 16;
   localparam int COUNT_WIDTH = $clog2(DEPTH + 1);
   localparam int DATA_WIDTH  = 32;

   // Item actions
   typedef enum logic [1:0] {
      ACT_PUSH  = 2'd0,
      ACT_POP   = 2'd1,
      ACT_CLEAR = 2'd2
   } action_type;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2
   } status_type;

   // One stored entry
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic signed [DATA_WIDTH-1:0] rank;
   } entry_type;

   // Broadcast control to every cell
   typedef struct packed {
      logic      push_en;
      logic      pop_en;
      entry_type new_entry;
   } cell_ctrl_type;

endpackage

[src/sorted_priority_queue.sv]
// ----------------------------------------------------------------------------
// sorted_priority_queue: stable minimum priority queue, sorted on insert
// Smallest rank is served first; equal ranks leave in arrival order.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser[1:0] carries the action (push, pop, clear); tdata holds
//   the item value and rank. rsp channel: one item per accepted request with
//   status and head flag in tuser, popped value, head value and fill count
//   in tdata.
//   The response is registered at the edge that accepts the request.
//   Throughput is one item per cycle while responses flow; every cell of the
//   row compares its rank with the new one in parallel, shifting in one step.
//   While a response waits on a stalled receiver, req_tready stays high only
//   if that response is taken in the same cycle; otherwise input is held off.
//   Reset empties the queue (fill count zero) and drops any pending response.
//   Cell contents are not cleared; only slots below the fill count are read.
//   A push into a full queue is dropped with status full; a pop on an empty
//   queue returns status empty and a zero value.
// ----------------------------------------------------------------------------
module sorted_priority_queue (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] item_value, [63:32] item_rank
   input  logic [1:0]  req_tuser,   // [1:0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata,   // [31:0] popped_value, [63:32] head_value,
                                    // [68:64] fill_count, [71:69] zero
   output logic [2:0]  rsp_tuser    // [1:0] status, [2] head_valid
);
   import spq_pkg::*;

   logic [COUNT_WIDTH-1:0] count_ff;
   logic [COUNT_WIDTH-1:0] count_in;
   logic                   rsp_valid_ff;
   logic                   rsp_valid_in;
   logic [71:0]            rsp_data_ff;
   logic [71:0]            rsp_data_in;
   logic [2:0]             rsp_user_ff;
   logic [2:0]             rsp_user_in;

   logic          accept;
   action_type    action;
   logic          is_full;
   logic          is_empty;
   status_type    status;
   cell_ctrl_type ctrl;

   entry_type             cell_entry [DEPTH];
   entry_type             cell_next  [DEPTH];
   logic      [DEPTH-1:0] cell_gt;

   logic signed [DATA_WIDTH-1:0] popped_value;
   logic signed [DATA_WIDTH-1:0] head_value;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign action     = action_type'(req_tuser);
   assign is_full    = (count_ff == COUNT_WIDTH'(DEPTH));
   assign is_empty   = (count_ff == '0);

   // Decode the action into cell controls, next count and status
   always_comb begin
      ctrl.push_en         = 1'b0;
      ctrl.pop_en          = 1'b0;
      ctrl.new_entry.value = $signed(req_tdata[31:0]);
      ctrl.new_entry.rank  = $signed(req_tdata[63:32]);
      count_in             = count_ff;
      status               = ST_OK;
      popped_value         = '0;
      case (action)
         ACT_PUSH: begin
            if (is_full) begin
               status = ST_FULL;
            end else begin
               ctrl.push_en = accept;
               count_in     = count_ff + COUNT_WIDTH'(1);
            end
         end
         ACT_POP: begin
            if (is_empty) begin
               status = ST_EMPTY;
            end else begin
               ctrl.pop_en  = accept;
               count_in     = count_ff - COUNT_WIDTH'(1);
               popped_value = cell_entry[0].value;
            end
         end
         ACT_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // Row of cells; each sees its neighbors' entries and its left neighbor's compare flag
   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic      left_gt;
      entry_type left_entry;
      entry_type right_entry;

      if (i == 0) begin : g_first
         assign left_gt    = 1'b0;
         assign left_entry = cell_entry[0];
      end else begin : g_inner
         assign left_gt    = cell_gt[i-1];
         assign left_entry = cell_entry[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry = cell_entry[i];
      end else begin : g_body
         assign right_entry = cell_entry[i+1];
      end

      spq_cell u_cell (
         .clock       (clock),
         .ctrl        (ctrl),
         .occupied    (count_ff > COUNT_WIDTH'(i)),
         .at_tail     (count_ff == COUNT_WIDTH'(i)),
         .left_gt     (left_gt),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .gt          (cell_gt[i]),
         .entry       (cell_entry[i]),
         .entry_next  (cell_next[i])
      );
   end

   // Build the response from the state after this item
   assign head_value = (count_in != '0) ? cell_next[0].value : '0;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {3'b000, count_in, head_value, popped_value};
         rsp_user_in  = {(count_in != '0), status};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Hold count and response handshake state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload needs no reset
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   // Fill count never exceeds the row length
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_WIDTH'(DEPTH))
      else $error("fill count beyond depth");

   // A push into a full queue leaves it full
   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      (accept && action == ACT_PUSH && is_full) |=> (count_ff == COUNT_WIDTH'(DEPTH)))
      else $error("dropped push changed fill count");

   // A clear empties the queue
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (accept && action == ACT_CLEAR) |=> (count_ff == '0))
      else $error("clear left entries");

   // Head flag in a response matches its fill count
   a_head_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_user_ff[2] == (rsp_data_ff[68:64] != 5'd0)))
      else $error("head flag disagrees with fill count");

   // An accepted item always yields a pending response next cycle
   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff)
      else $error("accepted item without response");

endmodule

[src/spq_cell.sv]
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted shift-register queue
// Holds one entry, compares its rank with an incoming one, and shifts right
// on insert or left on removal together with its neighbors.
// ----------------------------------------------------------------------------
module spq_cell (
   input  logic                   clock,
   input  spq_pkg::cell_ctrl_type ctrl,
   input  logic                   occupied,
   input  logic                   at_tail,
   input  logic                   left_gt,
   input  spq_pkg::entry_type     left_entry,
   input  spq_pkg::entry_type     right_entry,
   output logic                   gt,
   output spq_pkg::entry_type     entry,
   output spq_pkg::entry_type     entry_next
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   // Flag a held rank strictly above the new one; ties keep arrival order
   assign gt = occupied && (entry_ff.rank > ctrl.new_entry.rank);

   // Pick the next entry: shift in from the left, take the new item, shift in from the right, or hold
   always_comb begin
      entry_in = entry_ff;
      if (ctrl.push_en) begin
         if (left_gt) begin
            entry_in = left_entry;
         end else if (gt || at_tail) begin
            entry_in = ctrl.new_entry;
         end
      end else if (ctrl.pop_en) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry      = entry_ff;
   assign entry_next = entry_in;

endmodule

[dv/sorted_priority_queue_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_checker: scoreboard for the sorted priority queue
// Watches both stream channels, keeps its own copy of the queue contents,
// predicts the response for every accepted request and compares each
// accepted response field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module sorted_priority_queue_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [63:0] req_tdata,   // [31:0] item_value, [63:32] item_rank
   input  logic [1:0]  req_tuser,   // [1:0] action
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [71:0] rsp_tdata,   // [31:0] popped_value, [63:32] head_value,
                                    // [68:64] fill_count
   input  logic [2:0]  rsp_tuser,   // [1:0] status, [2] head_valid
   output int          fail_count,
   output int          open_count,
   output int          result_count,
   output int          full_count,
   output int          empty_count,
   output int          peak_fill
);
   import spq_pkg::*;

   // Predicted response of one request
   typedef struct {
      status_type                   status;
      logic signed [DATA_WIDTH-1:0] popped_value;
      logic signed [DATA_WIDTH-1:0] head_value;
      logic                         head_valid;
      logic [COUNT_WIDTH-1:0]       fill_count;
   } queue_result_type;

   // Shadow copy of the queue, smallest rank at slot zero
   logic signed [DATA_WIDTH-1:0] shadow_values [DEPTH];
   logic signed [DATA_WIDTH-1:0] shadow_ranks  [DEPTH];
   int                           shadow_fill;

   queue_result_type due_results [$];
   queue_result_type oldest_due;

   initial begin
      fail_count   = 0;
      open_count   = 0;
      result_count = 0;
      full_count   = 0;
      empty_count  = 0;
      peak_fill    = 0;
      shadow_fill  = 0;
   end

   // Apply one action to the shadow queue and return the response it gives
   function automatic queue_result_type serve_action(
      input action_type                   act,
      input logic signed [DATA_WIDTH-1:0] value,
      input logic signed [DATA_WIDTH-1:0] rank
   );
      queue_result_type res;
      int               slot;
      bit               found;
      res.status       = ST_OK;
      res.popped_value = '0;
      case (act)
         ACT_PUSH: begin
            if (shadow_fill >= DEPTH) begin
               res.status = ST_FULL;
            end else begin
               // insert behind every entry of equal or smaller rank
               slot  = shadow_fill;
               found = 1'b0;
               for (int i = 0; i < shadow_fill; i++) begin
                  if (!found && shadow_ranks[i] > rank) begin
                     slot  = i;
                     found = 1'b1;
                  end
               end
               for (int i = shadow_fill; i > slot; i--) begin
                  shadow_values[i] = shadow_values[i-1];
                  shadow_ranks[i]  = shadow_ranks[i-1];
               end
               shadow_values[slot] = value;
               shadow_ranks[slot]  = rank;
               shadow_fill++;
            end
         end
         ACT_POP: begin
            if (shadow_fill == 0) begin
               res.status = ST_EMPTY;
            end else begin
               res.popped_value = shadow_values[0];
               for (int i = 1; i < shadow_fill; i++) begin
                  shadow_values[i-1] = shadow_values[i];
                  shadow_ranks[i-1]  = shadow_ranks[i];
               end
               shadow_fill--;
            end
         end
         ACT_CLEAR: begin
            shadow_fill = 0;
         end
         default: begin
            // unused action code leaves the queue alone
         end
      endcase
      res.head_valid = (shadow_fill != 0);
      res.head_value = res.head_valid ? shadow_values[0] : '0;
      res.fill_count = shadow_fill[COUNT_WIDTH-1:0];
      return res;
   endfunction

   // Print one failure line and count it
   task automatic flag_error(input string msg);
      $display("%0t ns: ERROR: %s", $time, msg);
      fail_count++;
   endtask

   task automatic compare_field(input string name, input logic [31:0] got,
                                input logic [31:0] want);
      if (got !== want) begin
         flag_error($sformatf("response %0d: %s is %h, expected %h",
                              result_count, name, got, want));
      end
   endtask

   // Compare an accepted response against the oldest prediction
   task automatic check_response();
      if (due_results.size() == 0) begin
         flag_error($sformatf("response %0d arrived with no request outstanding",
                              result_count));
      end else begin
         oldest_due = due_results.pop_front();
         compare_field("status", 32'(rsp_tuser[1:0]), 32'(oldest_due.status));
         compare_field("popped_value", rsp_tdata[31:0], oldest_due.popped_value);
         compare_field("head_value", rsp_tdata[63:32], oldest_due.head_value);
         compare_field("head_valid", 32'(rsp_tuser[2]), 32'(oldest_due.head_valid));
         compare_field("fill_count", 32'(rsp_tdata[68:64]),
                       32'(oldest_due.fill_count));
         if (oldest_due.status == ST_FULL) full_count++;
         if (oldest_due.status == ST_EMPTY) empty_count++;
         if (int'(oldest_due.fill_count) > peak_fill) begin
            peak_fill = int'(oldest_due.fill_count);
         end
      end
      result_count++;
   endtask

   // Track both channels; responses first, since a request's response
   // can never be taken at the edge that accepts the request
   always @(posedge clock) begin
      if (reset) begin
         shadow_fill = 0;
         due_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            check_response();
         end
         if (req_tvalid && req_tready) begin
            due_results.push_back(serve_action(action_type'(req_tuser),
                                               req_tdata[31:0], req_tdata[63:32]));
         end
      end
      open_count <= due_results.size();
   end

endmodule

[dv/sorted_priority_queue_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_test: top of the sorted priority queue testbench
// Drives a directed opening (extreme ranks, rank ties, empty and full queue,
// clear, unused action) and then random blocks biased to fill, drain or
// churn the queue, with random gaps on the request side and random stalls
// on the response side. The checker scores every response.
// ----------------------------------------------------------------------------
module sorted_priority_queue_test;
   import spq_pkg::*;

   localparam logic [1:0] ACT_UNUSED   = 2'd3;
   localparam int         ITEM_TARGET  = 1100;
   localparam int         IDLE_LIMIT   = 2000;
   localparam int         SETTLE_TICKS = 8;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic [63:0] req_tdata  = '0;   // [31:0] item_value, [63:32] item_rank
   logic [1:0]  req_tuser  = '0;   // [1:0] action
   logic        rsp_tready = 1'b0;
   logic        req_tready;
   logic        rsp_tvalid;
   logic [71:0] rsp_tdata;         // [31:0] popped_value, [63:32] head_value,
                                   // [68:64] fill_count
   logic [2:0]  rsp_tuser;         // [1:0] status, [2] head_valid

   int fail_count;
   int open_count;
   int result_count;
   int full_count;
   int empty_count;
   int peak_fill;

   int stall_pct   = 0;
   int stall_left  = 0;
   int idle_cycles = 0;
   bit steady_send = 1'b0;
   int items_sent  = 0;
   int push_sent   = 0;
   int pop_sent    = 0;
   int clear_sent  = 0;
   int unused_sent = 0;

   always #5 clock = ~clock;

   sorted_priority_queue u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   sorted_priority_queue_checker u_checker (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .fail_count   (fail_count),
      .open_count   (open_count),
      .result_count (result_count),
      .full_count   (full_count),
      .empty_count  (empty_count),
      .peak_fill    (peak_fill)
   );

   // Idle length: mostly none or short, now and then long
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 40);
   endfunction

   // Rank: narrow range for plenty of ties, some extremes, some full range
   function automatic logic [31:0] pick_rank();
      int roll;
      roll = $urandom_range(0, 9);
      if (roll < 5) return $urandom_range(0, 7);
      if (roll == 5) begin
         case ($urandom_range(0, 3))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2:       return 32'hffff_ffff;
            default: return 32'h0000_0000;
         endcase
      end
      return $urandom;
   endfunction

   // Present one item and hold it until accepted, then maybe idle
   task automatic send_item(input logic [1:0] act, input logic [31:0] value,
                            input logic [31:0] rank);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {rank, value};
      do @(posedge clock); while (!req_tready);
      items_sent++;
      case (act)
         ACT_PUSH:  push_sent++;
         ACT_POP:   pop_sent++;
         ACT_CLEAR: clear_sent++;
         default:   unused_sent++;
      endcase
      gap = steady_send ? 0 : pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Hold off input until every outstanding response has been taken
   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (open_count != 0) @(posedge clock);
   endtask

   // Response side: random stalls of random length
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left != 0) begin
         rsp_tready <= 1'b0;
         stall_left = stall_left - 1;
      end else if ($urandom_range(0, 99) < stall_pct) begin
         rsp_tready <= 1'b0;
         stall_left = pick_gap();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: end the run when no item moves on either channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles = idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t ns: timeout, no item moved for %0d cycles", $time, IDLE_LIMIT);
         $display("sorted_priority_queue test failed");
         $finish;
      end
   end

   initial begin
      int         block_items;
      int         block_count;
      int         push_limit;
      int         roll;
      logic [1:0] act;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed opening: empty pop, extreme ranks, ties, unused action, clear
      stall_pct = 20;
      send_item(ACT_POP, $urandom, $urandom);
      send_item(ACT_PUSH, 32'h7fff_ffff, 32'h7fff_ffff);
      send_item(ACT_PUSH, 32'h8000_0000, 32'h8000_0000);
      send_item(ACT_PUSH, 32'hffff_ffff, 32'h0000_0000);
      send_item(ACT_PUSH, 32'h0000_0001, 32'h0000_0000);
      send_item(ACT_UNUSED, $urandom, $urandom);
      send_item(ACT_POP, $urandom, $urandom);
      send_item(ACT_CLEAR, $urandom, $urandom);

      // Fill to the top, each new rank the smallest so far, then overflow
      for (int i = 0; i < DEPTH; i++) begin
         send_item(ACT_PUSH, $urandom, 32'(DEPTH - i));
      end
      send_item(ACT_PUSH, $urandom, 32'h8000_0000);
      wait_for_drain();

      // Random blocks, each biased to fill, drain or churn the queue
      block_count = 0;
      while (items_sent < ITEM_TARGET) begin
         case ($urandom_range(0, 2))
            0:       push_limit = 75;
            1:       push_limit = 30;
            default: push_limit = 52;
         endcase
         case ($urandom_range(0, 3))
            0:       stall_pct = 0;
            1:       stall_pct = 10;
            2:       stall_pct = 30;
            default: stall_pct = 60;
         endcase
         steady_send = ($urandom_range(0, 3) == 0);
         block_items = $urandom_range(30, 120);
         repeat (block_items) begin
            roll = $urandom_range(0, 99);
            if (roll < 2) act = ACT_CLEAR;
            else if (roll < 3) act = ACT_UNUSED;
            else if (roll < push_limit) act = ACT_PUSH;
            else act = ACT_POP;
            send_item(act, $urandom, pick_rank());
         end
         if (block_count % 3 == 0) wait_for_drain();
         block_count++;
      end

      // Let every outstanding response come back, then settle
      wait_for_drain();
      repeat (SETTLE_TICKS) @(posedge clock);

      $display("Sent %0d items: %0d push, %0d pop, %0d clear, %0d unused action",
               items_sent, push_sent, pop_sent, clear_sent, unused_sent);
      $display("Scored %0d responses: %0d full-queue drops, %0d empty pops, peak fill %0d",
               result_count, full_count, empty_count, peak_fill);
      if (fail_count == 0) begin
         $display("sorted_priority_queue test passed");
      end else begin
         $display("sorted_priority_queue test failed");
      end
      $finish;
   end

endmodule
